>>> rtl/easa_pkg.sv
// Shared types and constants for the expert activation sum-of-squares accumulator.
// Used by every module of the block but easa_ram; depends on nothing else.
`default_nettype none

package easa_pkg;

   // Default sizing of the sum and row-count tables
   localparam int DEF_MAX_LAYERS      = 4;
   localparam int DEF_MAX_EXPERTS     = 8;
   localparam int DEF_MAX_COLUMNS     = 256;
   localparam int DEF_NUM_PROJECTIONS = 3;

   // Projection codes the table layout knows about
   localparam int PROJ_LIMIT = 3;

   // Configuration register reset values
   localparam logic [2:0] LAYERS_RESET  = 3'd4;
   localparam logic [3:0] EXPERTS_RESET = 4'd8;
   localparam logic [8:0] COLUMNS_RESET = 9'd256;

   // Field widths
   localparam int CSR_DATA_W = 9;
   localparam int ACT_W      = 24;
   localparam int SQ_W       = 2 * ACT_W;
   localparam int SUM_W      = 64;
   localparam int CNT_W      = 32;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ACCUMULATE    = 2'd0,
      CMD_READ_SUM      = 2'd1,
      CMD_READ_COUNT    = 2'd2,
      CMD_READ_COUNTERS = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PROJ_GATE    = 2'd0,
      PROJ_UP      = 2'd1,
      PROJ_DOWN    = 2'd2,
      PROJ_INVALID = 2'd3
   } proj_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_ADDR   = 2'd1,
      ST_BAD_EXPERT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CSR_LAYERS       = 3'd0,
      CSR_EXPERTS      = 3'd1,
      CSR_GATE_COLUMNS = 3'd2,
      CSR_UP_COLUMNS   = 3'd3,
      CSR_DOWN_COLUMNS = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_UPDATE
   } back_state_type;

   // One classified transaction waiting for the back end
   typedef struct packed {
      cmd_type            cmd;
      status_type         status;
      logic [1:0]         projection;
      logic [7:0]         layer;
      logic [15:0]        expert_id;
      logic [11:0]        column;
      logic [ACT_W-1:0]   activation;
      logic               not_finite;
      logic               first_of_row;
      logic               end_of_call;
   } queue_entry_type;

   typedef struct packed {
      logic               full;
      logic [QCNT_W-1:0]  count;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/expert_activation_sumsq_accumulator.sv
// Expert activation sum-of-squares accumulator. Each accumulate transaction squares one
// signed Q8.16 activation and adds it, saturating, into a Q32.32 sum kept per projection,
// layer, expert and column; a row count per projection, layer and expert rises on the first
// element of a row, and global counters track non-finite elements, rows with a bad expert id
// and finished observation batches. Every transaction returns one result, in order; a read
// returns a sum, a row count or the counters. After reset the block runs a clearing pass
// over the NUM_PROJECTIONS*MAX_LAYERS*MAX_EXPERTS*MAX_COLUMNS entries of the sum table (24576
// with the default sizes), also zeroing the row-count table, during which req_ready is low;
// configuration writes are taken at any time and act at once. A front end classifies
// transactions into a two-entry queue; the back end reads the tables in BK_READ and updates
// them in BK_UPDATE, one transaction at a time, passing through BK_IDLE when the queue has
// run empty; BK_UPDATE holds while the result register is full and not yet taken.
// Depends on easa_pkg, easa_front, easa_queue, easa_back and easa_ram.
`default_nettype none

module expert_activation_sumsq_accumulator #(
   parameter int MAX_LAYERS      = easa_pkg::DEF_MAX_LAYERS,
   parameter int MAX_EXPERTS     = easa_pkg::DEF_MAX_EXPERTS,
   parameter int MAX_COLUMNS     = easa_pkg::DEF_MAX_COLUMNS,
   parameter int NUM_PROJECTIONS = easa_pkg::DEF_NUM_PROJECTIONS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [easa_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_command,
   input  wire logic [1:0]                           req_projection,
   input  wire logic [7:0]                           req_layer,
   input  wire logic signed [15:0]                   req_expert_id,
   input  wire logic [11:0]                          req_column,
   input  wire logic signed [easa_pkg::ACT_W-1:0]    req_activation,
   input  wire logic                                 req_not_finite,
   input  wire logic                                 req_first_of_row,
   input  wire logic                                 req_end_of_call,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [1:0]                                rsp_status,
   output logic [easa_pkg::SUM_W-1:0]                rsp_sum_value,
   output logic [easa_pkg::CNT_W-1:0]                rsp_count_value,
   output logic [easa_pkg::CNT_W-1:0]                rsp_nonfinite_total,
   output logic [easa_pkg::CNT_W-1:0]                rsp_bad_id_total,
   output logic [easa_pkg::CNT_W-1:0]                rsp_observation_total
);

   import easa_pkg::*;

   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   logic             back_busy;

   // Accept and classify
   easa_front #(
      .MAX_LAYERS      (MAX_LAYERS),
      .MAX_EXPERTS     (MAX_EXPERTS),
      .MAX_COLUMNS     (MAX_COLUMNS),
      .NUM_PROJECTIONS (NUM_PROJECTIONS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_projection   (req_projection),
      .req_layer        (req_layer),
      .req_expert_id    (req_expert_id),
      .req_column       (req_column),
      .req_activation   (req_activation),
      .req_not_finite   (req_not_finite),
      .req_first_of_row (req_first_of_row),
      .req_end_of_call  (req_end_of_call),
      .back_busy        (back_busy),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   // Decouple front and back
   easa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // Carry out table updates and reads
   easa_back #(
      .MAX_LAYERS      (MAX_LAYERS),
      .MAX_EXPERTS     (MAX_EXPERTS),
      .MAX_COLUMNS     (MAX_COLUMNS),
      .NUM_PROJECTIONS (NUM_PROJECTIONS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head                  (head_entry),
      .q_status              (q_status),
      .q_pop                 (q_pop),
      .busy                  (back_busy),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_sum_value         (rsp_sum_value),
      .rsp_count_value       (rsp_count_value),
      .rsp_nonfinite_total   (rsp_nonfinite_total),
      .rsp_bad_id_total      (rsp_bad_id_total),
      .rsp_observation_total (rsp_observation_total)
   );

endmodule

`default_nettype wire

>>> rtl/easa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the sum and row-count tables; no package dependency.
`default_nettype none

module easa_ram #(
   parameter int     WIDTH = 32,
   parameter longint DEPTH = 16,
   localparam int    AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/easa_front.sv
// Front end: configuration registers, input handshake and address/status classification.
// Depends on easa_pkg; feeds easa_queue.
`default_nettype none

module easa_front #(
   parameter int MAX_LAYERS      = easa_pkg::DEF_MAX_LAYERS,
   parameter int MAX_EXPERTS     = easa_pkg::DEF_MAX_EXPERTS,
   parameter int MAX_COLUMNS     = easa_pkg::DEF_MAX_COLUMNS,
   parameter int NUM_PROJECTIONS = easa_pkg::DEF_NUM_PROJECTIONS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [easa_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_command,
   input  wire logic [1:0]                           req_projection,
   input  wire logic [7:0]                           req_layer,
   input  wire logic signed [15:0]                   req_expert_id,
   input  wire logic [11:0]                          req_column,
   input  wire logic signed [easa_pkg::ACT_W-1:0]    req_activation,
   input  wire logic                                 req_not_finite,
   input  wire logic                                 req_first_of_row,
   input  wire logic                                 req_end_of_call,
   input  wire logic                                 back_busy,
   input  wire easa_pkg::queue_status_type           q_status,
   output logic                                      q_push,
   output easa_pkg::queue_entry_type                 q_entry
);

   import easa_pkg::*;

   logic [2:0] layers_ff;
   logic [3:0] experts_ff;
   logic [8:0] gate_cols_ff;
   logic [8:0] up_cols_ff;
   logic [8:0] down_cols_ff;

   logic       proj_ok;
   logic       layer_ok;
   logic       addr_ok;
   logic       col_ok;
   logic       exp_ok;
   logic [8:0] width_sel;
   status_type status;

   assign csr_ready = 1'b1;

   // Configuration writes, taken at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         layers_ff    <= LAYERS_RESET;
         experts_ff   <= EXPERTS_RESET;
         gate_cols_ff <= COLUMNS_RESET;
         up_cols_ff   <= COLUMNS_RESET;
         down_cols_ff <= COLUMNS_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LAYERS:       layers_ff    <= csr_data[2:0];
            CSR_EXPERTS:      experts_ff   <= csr_data[3:0];
            CSR_GATE_COLUMNS: gate_cols_ff <= csr_data[8:0];
            CSR_UP_COLUMNS:   up_cols_ff   <= csr_data[8:0];
            CSR_DOWN_COLUMNS: down_cols_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // Pick the row width of the addressed projection
   always_comb begin
      unique case (req_projection)
         PROJ_GATE: width_sel = gate_cols_ff;
         PROJ_UP:   width_sel = up_cols_ff;
         PROJ_DOWN: width_sel = down_cols_ff;
         default:   width_sel = 9'd0;
      endcase
   end

   // Check each address part against the table size and, but for the projection, its register
   always_comb begin
      proj_ok  = (32'(req_projection) < NUM_PROJECTIONS) &&
                 (32'(req_projection) < PROJ_LIMIT);
      layer_ok = ({5'b0, layers_ff} > req_layer) && (32'(req_layer) < MAX_LAYERS);
      addr_ok  = proj_ok && layer_ok;
      col_ok   = ({3'b0, width_sel} > req_column) && (32'(req_column) < MAX_COLUMNS);
      exp_ok   = !req_expert_id[15] &&
                 ({12'b0, experts_ff} > $unsigned(req_expert_id)) &&
                 (32'(req_expert_id[14:0]) < MAX_EXPERTS);
   end

   // Classify the transaction
   always_comb begin
      unique case (cmd_type'(req_command)) inside
         CMD_ACCUMULATE, CMD_READ_SUM: begin
            if (!addr_ok || !col_ok) begin
               status = ST_BAD_ADDR;
            end else if (!exp_ok) begin
               status = ST_BAD_EXPERT;
            end else begin
               status = ST_OK;
            end
         end
         CMD_READ_COUNT: begin
            if (!addr_ok) begin
               status = ST_BAD_ADDR;
            end else if (!exp_ok) begin
               status = ST_BAD_EXPERT;
            end else begin
               status = ST_OK;
            end
         end
         default: status = ST_OK;
      endcase
   end

   // Hand classified transactions to the queue
   assign req_ready = !back_busy && !q_status.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_entry.cmd          = cmd_type'(req_command);
      q_entry.status       = status;
      q_entry.projection   = req_projection;
      q_entry.layer        = req_layer;
      q_entry.expert_id    = req_expert_id;
      q_entry.column       = req_column;
      q_entry.activation   = req_activation;
      q_entry.not_finite   = req_not_finite;
      q_entry.first_of_row = req_first_of_row;
      q_entry.end_of_call  = req_end_of_call;
   end

endmodule

`default_nettype wire

>>> rtl/easa_queue.sv
// Short register queue between the classifying front end and the table back end.
// Depends on easa_pkg for the entry and status types.
`default_nettype none

module easa_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire easa_pkg::queue_entry_type  push_entry,
   input  wire logic                       pop,
   output easa_pkg::queue_entry_type       head_entry,
   output easa_pkg::queue_status_type      status
);

   import easa_pkg::*;

   queue_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.count = count_ff;

endmodule

`default_nettype wire

>>> rtl/easa_back.sv
// Back end: clearing pass, read-modify-write of the sum and row-count tables,
// global counters and the result register. Depends on easa_pkg and easa_ram.
`default_nettype none

module easa_back #(
   parameter int MAX_LAYERS      = easa_pkg::DEF_MAX_LAYERS,
   parameter int MAX_EXPERTS     = easa_pkg::DEF_MAX_EXPERTS,
   parameter int MAX_COLUMNS     = easa_pkg::DEF_MAX_COLUMNS,
   parameter int NUM_PROJECTIONS = easa_pkg::DEF_NUM_PROJECTIONS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire easa_pkg::queue_entry_type      head,
   input  wire easa_pkg::queue_status_type     q_status,
   output logic                                q_pop,
   output logic                                busy,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [easa_pkg::SUM_W-1:0]          rsp_sum_value,
   output logic [easa_pkg::CNT_W-1:0]          rsp_count_value,
   output logic [easa_pkg::CNT_W-1:0]          rsp_nonfinite_total,
   output logic [easa_pkg::CNT_W-1:0]          rsp_bad_id_total,
   output logic [easa_pkg::CNT_W-1:0]          rsp_observation_total
);

   import easa_pkg::*;

   localparam longint ROW_DEPTH = longint'(NUM_PROJECTIONS) * MAX_LAYERS * MAX_EXPERTS;
   localparam longint SUM_DEPTH = ROW_DEPTH * MAX_COLUMNS;
   localparam int     ROW_AW    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
   localparam int     SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [SUM_AW-1:0] clr_ff;
   logic [SUM_AW-1:0] clr_in;

   logic [SQ_W-1:0]   sq_ff;
   logic [ACT_W-1:0]  mag;

   logic [CNT_W-1:0]  nonfinite_ff;
   logic [CNT_W-1:0]  nonfinite_in;
   logic [CNT_W-1:0]  bad_id_ff;
   logic [CNT_W-1:0]  bad_id_in;
   logic [CNT_W-1:0]  observation_ff;
   logic [CNT_W-1:0]  observation_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic [SUM_W-1:0]  rsp_sum_ff;
   logic [SUM_W-1:0]  rsp_sum_in;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic [CNT_W-1:0]  rsp_count_in;
   logic [CNT_W-1:0]  rsp_nonfinite_ff;
   logic [CNT_W-1:0]  rsp_bad_id_ff;
   logic [CNT_W-1:0]  rsp_observation_ff;
   logic              rsp_load;

   logic [ROW_AW-1:0] row_idx;
   logic [SUM_AW-1:0] sum_idx;
   logic              rd_en;
   logic              sum_wr_en;
   logic [SUM_AW-1:0] sum_wr_addr;
   logic [SUM_W-1:0]  sum_wr_data;
   logic [SUM_W-1:0]  sum_rd_data;
   logic              row_wr_en;
   logic [ROW_AW-1:0] row_wr_addr;
   logic [CNT_W-1:0]  row_wr_data;
   logic [CNT_W-1:0]  row_rd_data;
   logic [SUM_W:0]    sum_add;
   logic              acc_ok;

   // Table addresses of the transaction at the queue head
   always_comb begin
      row_idx = ROW_AW'((64'(head.projection) * MAX_LAYERS + 64'(head.layer)) * MAX_EXPERTS
                        + 64'(head.expert_id[14:0]));
      sum_idx = SUM_AW'(64'(row_idx) * MAX_COLUMNS + 64'(head.column));
   end

   // Square of the activation magnitude, registered during the read cycle
   assign mag = head.activation[ACT_W-1] ? (~head.activation + 1'b1) : head.activation;

   always_ff @(posedge clock) begin
      if (state_ff == BK_READ) begin
         sq_ff <= SQ_W'(mag) * SQ_W'(mag);
      end
   end

   assign sum_add = {1'b0, sum_rd_data} + (SUM_W + 1)'(sq_ff);
   assign acc_ok  = (head.cmd == CMD_ACCUMULATE) && (head.status == ST_OK);

   // Sequencer: clear, then read and update one transaction at a time
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      rd_en          = 1'b0;
      q_pop          = 1'b0;
      rsp_load       = 1'b0;
      sum_wr_en      = 1'b0;
      sum_wr_addr    = sum_idx;
      sum_wr_data    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      row_wr_en      = 1'b0;
      row_wr_addr    = row_idx;
      row_wr_data    = (row_rd_data == '1) ? row_rd_data : row_rd_data + 1'b1;
      nonfinite_in   = nonfinite_ff;
      bad_id_in      = bad_id_ff;
      observation_in = observation_ff;
      rsp_sum_in     = '0;
      rsp_count_in   = '0;
      unique case (state_ff)
         BK_CLEAR: begin
            sum_wr_en   = 1'b1;
            sum_wr_addr = clr_ff;
            sum_wr_data = '0;
            row_wr_en   = (64'(clr_ff) < ROW_DEPTH);
            row_wr_addr = clr_ff[ROW_AW-1:0];
            row_wr_data = '0;
            if (64'(clr_ff) == SUM_DEPTH - 1) begin
               state_in = BK_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (q_status.count != '0) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            rd_en    = 1'b1;
            state_in = BK_UPDATE;
         end
         BK_UPDATE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               q_pop    = 1'b1;
               if (head.cmd == CMD_ACCUMULATE) begin
                  if (head.status == ST_OK) begin
                     row_wr_en = head.first_of_row;
                     sum_wr_en = !head.not_finite;
                     if (head.not_finite && nonfinite_ff != '1) begin
                        nonfinite_in = nonfinite_ff + 1'b1;
                     end
                  end
                  if (head.status == ST_BAD_EXPERT && head.first_of_row &&
                      bad_id_ff != '1) begin
                     bad_id_in = bad_id_ff + 1'b1;
                  end
                  if (head.status != ST_BAD_ADDR && head.end_of_call &&
                      observation_ff != '1) begin
                     observation_in = observation_ff + 1'b1;
                  end
               end
               if (head.cmd == CMD_READ_SUM && head.status == ST_OK) begin
                  rsp_sum_in = sum_rd_data;
               end
               if (head.cmd == CMD_READ_COUNT && head.status == ST_OK) begin
                  rsp_count_in = row_rd_data;
               end
               state_in = (q_status.count > QCNT_W'(1)) ? BK_READ : BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Result register: load on update, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BK_CLEAR;
         clr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         nonfinite_ff   <= '0;
         bad_id_ff      <= '0;
         observation_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         nonfinite_ff   <= nonfinite_in;
         bad_id_ff      <= bad_id_in;
         observation_ff <= observation_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff      <= head.status;
         rsp_sum_ff         <= rsp_sum_in;
         rsp_count_ff       <= rsp_count_in;
         rsp_nonfinite_ff   <= nonfinite_in;
         rsp_bad_id_ff      <= bad_id_in;
         rsp_observation_ff <= observation_in;
      end
   end

   // Sum and row-count tables
   easa_ram #(
      .WIDTH (SUM_W),
      .DEPTH (SUM_DEPTH)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_wr_en),
      .wr_addr (sum_wr_addr),
      .wr_data (sum_wr_data),
      .rd_en   (rd_en),
      .rd_addr (sum_idx),
      .rd_data (sum_rd_data)
   );

   easa_ram #(
      .WIDTH (CNT_W),
      .DEPTH (ROW_DEPTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_wr_en),
      .wr_addr (row_wr_addr),
      .wr_data (row_wr_data),
      .rd_en   (rd_en),
      .rd_addr (row_idx),
      .rd_data (row_rd_data)
   );

   assign busy                  = (state_ff == BK_CLEAR);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_sum_value         = rsp_sum_ff;
   assign rsp_count_value       = rsp_count_ff;
   assign rsp_nonfinite_total   = rsp_nonfinite_ff;
   assign rsp_bad_id_total      = rsp_bad_id_ff;
   assign rsp_observation_total = rsp_observation_ff;

   // Pop only a queue that holds a transaction
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_status.count != '0))
      else $error("queue popped while empty");

   // Outside the clearing pass the sum table changes only for good accumulates
   assert property (@(posedge clock) disable iff (reset)
      (sum_wr_en && state_ff != BK_CLEAR) |-> acc_ok)
      else $error("sum table written by a non-accumulating transaction");

   // An update with a free result register always delivers
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_UPDATE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff != BK_UPDATE))
      else $error("update stalled with a free result register");

endmodule

`default_nettype wire
